### rtl/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg: shared types and helpers of the mask bounding box finder
// Register map, field widths, queue entry layout and the margin arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package bbf_pkg;

    // Default values for the top-level parameters.
    localparam int MAX_DIM_DEF    = 512;
    localparam int LABEL_BITS_DEF = 8;

    // Fixed field widths.
    localparam int SIZE_W = 10;
    localparam int PAD_W  = 9;
    localparam int OUT_W  = 9;
    localparam int CMP_W  = SIZE_W + 1;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Queue entry: {pos_x, pos_y, pos_z, nonzero, last}.
    localparam int ENT_LAST = 0;
    localparam int ENT_NZ   = 1;
    localparam int Q_DEPTH  = 2;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_SIZE_X = 3'd0,
        REG_SIZE_Y = 3'd1,
        REG_SIZE_Z = 3'd2,
        REG_PAD_X  = 3'd3,
        REG_PAD_Y  = 3'd4,
        REG_PAD_Z  = 3'd5
    } reg_idx_t;

    // Effective volume sizes and margins, as seen by the datapath.
    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [PAD_W-1:0]  pad_x;
        logic [PAD_W-1:0]  pad_y;
        logic [PAD_W-1:0]  pad_z;
    } cfg_t;

    // Low face moved outward by the margin, saturating at zero.
    function automatic logic [OUT_W-1:0] pad_low(input logic [SIZE_W-1:0] v,
                                                 input logic [PAD_W-1:0] pad);
        logic [SIZE_W-1:0] p;
        logic [SIZE_W-1:0] d;
        p = SIZE_W'(pad);
        d = v - p;
        return (v > p) ? d[OUT_W-1:0] : '0;
    endfunction

    // High face moved outward by the margin, saturating at size minus one.
    function automatic logic [OUT_W-1:0] pad_high(input logic [SIZE_W-1:0] v,
                                                  input logic [PAD_W-1:0] pad,
                                                  input logic [SIZE_W-1:0] size);
        logic [CMP_W-1:0] sum;
        logic [CMP_W-1:0] lim;
        sum = CMP_W'(v) + CMP_W'(pad);
        lim = CMP_W'(size) - CMP_W'(1);
        return (sum > lim) ? lim[OUT_W-1:0] : sum[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/bbf_if.sv
// ----------------------------------------------------------------------------
// bbf_in_if / bbf_out_if: voxel and result channels
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbf_in_if #(parameter int LABEL_BITS = 8) ();
    logic                  valid;
    logic                  ready;
    logic [LABEL_BITS-1:0] label;

    modport source (output valid, output label, input ready);
    modport sink   (input valid, input label, output ready);
endinterface

interface bbf_out_if import bbf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] low_x;
    logic [OUT_W-1:0] high_x;
    logic [OUT_W-1:0] low_y;
    logic [OUT_W-1:0] high_y;
    logic [OUT_W-1:0] low_z;
    logic [OUT_W-1:0] high_z;
    logic             mask_empty;

    modport source (output valid, output low_x, output high_x, output low_y,
                    output high_y, output low_z, output high_z, output mask_empty,
                    input ready);
    modport sink   (input valid, input low_x, input high_x, input low_y,
                    input high_y, input low_z, input high_z, input mask_empty,
                    output ready);
endinterface

`default_nettype wire

### rtl/bbf_front.sv
// ----------------------------------------------------------------------------
// bbf_front: voxel intake and position tracking
// Accepts labels, tags each with its position, a nonzero flag and an
// end-of-volume flag, and pushes the tagged voxel into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_front import bbf_pkg::*; #(
    parameter int POS_W      = 9,
    parameter int LABEL_BITS = LABEL_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    bbf_in_if.sink                  in_ch,
    input  wire cfg_t               cfg,
    output logic                    push_valid,
    output logic [3*POS_W+1:0]      push_data,
    input  wire logic               push_ready
);

    logic [POS_W-1:0]      pos_x_reg, pos_x_next;
    logic [POS_W-1:0]      pos_y_reg, pos_y_next;
    logic [POS_W-1:0]      pos_z_reg, pos_z_next;
    logic [LABEL_BITS-1:0] label_w;
    logic                  accept;
    logic                  nz;
    logic                  cz, cy, cx;

    // Handshake: the queue's free space is the only thing that stalls intake.
    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;
    assign accept      = in_ch.valid & push_ready;
    assign label_w     = in_ch.label;
    assign nz          = |label_w;

    // Wrap detection, z fastest, then y, then x.
    assign cz = (CMP_W'(pos_z_reg) + CMP_W'(1)) >= CMP_W'(cfg.size_z);
    assign cy = cz && ((CMP_W'(pos_y_reg) + CMP_W'(1)) >= CMP_W'(cfg.size_y));
    assign cx = cy && ((CMP_W'(pos_x_reg) + CMP_W'(1)) >= CMP_W'(cfg.size_x));

    assign push_data = {pos_x_reg, pos_y_reg, pos_z_reg, nz, cx};

    // Counter advance on every accepted voxel.
    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (accept)
        begin
            if (cx)
            begin
                pos_x_next = '0;
                pos_y_next = '0;
                pos_z_next = '0;
            end
            else if (!cz)
            begin
                pos_z_next = pos_z_reg + POS_W'(1);
            end
            else if (!cy)
            begin
                pos_z_next = '0;
                pos_y_next = pos_y_reg + POS_W'(1);
            end
            else
            begin
                pos_z_next = '0;
                pos_y_next = '0;
                pos_x_next = pos_x_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bbf_queue.sv
// ----------------------------------------------------------------------------
// bbf_queue: short queue between intake and box update
// Two-entry register queue; the head entry is presented combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_queue import bbf_pkg::*; #(
    parameter int WIDTH = 29
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data,
    input  wire logic             pop
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/bbf_back.sv
// ----------------------------------------------------------------------------
// bbf_back: running box update and result formation
// Folds each tagged voxel into the running min/max, snapshots the box at the
// end of a volume, then applies margin and clamp, or the empty-mask fallback, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_back import bbf_pkg::*; #(
    parameter int POS_W = 9
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire logic [3*POS_W+1:0] head_data,
    output logic                    pop,
    input  wire cfg_t               cfg,
    bbf_out_if.source               out_ch
);

    logic [POS_W-1:0] hd_pos [3];
    logic             hd_nz;
    logic             hd_last;

    logic             found_reg, found_next;
    logic [POS_W-1:0] min_reg [3];
    logic [POS_W-1:0] max_reg [3];
    logic [POS_W-1:0] min_new [3];
    logic [POS_W-1:0] max_new [3];

    logic             fin_v_reg, fin_v_next;
    logic             fin_found_reg;
    logic [POS_W-1:0] fin_min_reg [3];
    logic [POS_W-1:0] fin_max_reg [3];

    logic             out_v_reg, out_v_next;
    logic [OUT_W-1:0] low_x_reg, high_x_reg;
    logic [OUT_W-1:0] low_y_reg, high_y_reg;
    logic [OUT_W-1:0] low_z_reg, high_z_reg;
    logic             empty_reg;

    logic             fin_adv;
    logic             fin_free;

    // Unpack the head entry.
    assign hd_pos[0] = head_data[3*POS_W+1 -: POS_W];
    assign hd_pos[1] = head_data[2*POS_W+1 -: POS_W];
    assign hd_pos[2] = head_data[POS_W+1 -: POS_W];
    assign hd_nz     = head_data[ENT_NZ];
    assign hd_last   = head_data[ENT_LAST];

    // Flow control: plain voxels always drain, a closing voxel needs a free snapshot.
    assign fin_adv  = fin_v_reg & (~out_v_reg | out_ch.ready);
    assign fin_free = ~fin_v_reg | fin_adv;
    assign pop      = head_valid & (~hd_last | fin_free);

    // Running min/max including the head voxel, one lane per axis.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            min_new[i] = min_reg[i];
            max_new[i] = max_reg[i];
            if (hd_nz)
            begin
                if (!found_reg || (hd_pos[i] < min_reg[i]))
                begin
                    min_new[i] = hd_pos[i];
                end
                if (!found_reg || (hd_pos[i] > max_reg[i]))
                begin
                    max_new[i] = hd_pos[i];
                end
            end
        end
    end

    // Control state next values.
    always_comb
    begin
        found_next = found_reg;
        fin_v_next = fin_v_reg & ~fin_adv;
        out_v_next = out_v_reg & ~out_ch.ready;
        if (pop)
        begin
            found_next = hd_last ? 1'b0 : (found_reg | hd_nz);
            if (hd_last)
            begin
                fin_v_next = 1'b1;
            end
        end
        if (fin_adv)
        begin
            out_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            fin_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            fin_v_reg <= fin_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Running box and end-of-volume snapshot.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= min_new[i];
                max_reg[i] <= max_new[i];
            end
            if (hd_last)
            begin
                fin_found_reg <= found_reg | hd_nz;
                for (int i = 0; i < 3; i++)
                begin
                    fin_min_reg[i] <= min_new[i];
                    fin_max_reg[i] <= max_new[i];
                end
            end
        end
    end

    // Margin, clamp and the empty-mask fallback into the output register.
    always_ff @(posedge clk)
    begin
        if (fin_adv)
        begin
            if (fin_found_reg)
            begin
                low_x_reg  <= pad_low(SIZE_W'(fin_min_reg[0]), cfg.pad_x);
                high_x_reg <= pad_high(SIZE_W'(fin_max_reg[0]), cfg.pad_x, cfg.size_x);
                low_y_reg  <= pad_low(SIZE_W'(fin_min_reg[1]), cfg.pad_y);
                high_y_reg <= pad_high(SIZE_W'(fin_max_reg[1]), cfg.pad_y, cfg.size_y);
                low_z_reg  <= pad_low(SIZE_W'(fin_min_reg[2]), cfg.pad_z);
                high_z_reg <= pad_high(SIZE_W'(fin_max_reg[2]), cfg.pad_z, cfg.size_z);
                empty_reg  <= 1'b0;
            end
            else
            begin
                low_x_reg  <= '0;
                high_x_reg <= OUT_W'(cfg.size_x - SIZE_W'(1));
                low_y_reg  <= '0;
                high_y_reg <= OUT_W'(cfg.size_y - SIZE_W'(1));
                low_z_reg  <= '0;
                high_z_reg <= OUT_W'(cfg.size_z - SIZE_W'(1));
                empty_reg  <= 1'b1;
            end
        end
    end

    assign out_ch.valid      = out_v_reg;
    assign out_ch.low_x      = low_x_reg;
    assign out_ch.high_x     = high_x_reg;
    assign out_ch.low_y      = low_y_reg;
    assign out_ch.high_y     = high_y_reg;
    assign out_ch.low_z      = low_z_reg;
    assign out_ch.high_z     = high_z_reg;
    assign out_ch.mask_empty = empty_reg;

endmodule

`default_nettype wire

### rtl/mask_bounding_box_finder.sv
// ----------------------------------------------------------------------------
// mask_bounding_box_finder: padded bounding box of a 3D label mask
// Streams label voxels (z fastest, then y, then x) and reports one box per
// volume, widened by per-axis margins and clamped to the volume.
// ----------------------------------------------------------------------------
// The block takes one voxel per clock cycle unless unread results hold back a
// closing voxel; the back end folds each popped voxel into the running min/max.
// The intake tags each voxel with its position and passes it through a two-entry
// queue to the box update; a result goes via the end-of-volume snapshot into the
// output register; the next volume keeps streaming in while it waits to be read.
// There is no start-up clearing pass. Registers at byte addresses 0x00..0x14:
// size_x, size_y, size_z (0 acts as 1, values above MAX_DIM act as MAX_DIM),
// then pad_x, pad_y, pad_z; write them only while no volume is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mask_bounding_box_finder import bbf_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int LABEL_BITS = LABEL_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    bbf_in_if.sink                 in_ch,
    bbf_out_if.source              out_ch
);

    localparam int DIM_CAP = (MAX_DIM > 1023) ? 1023 : MAX_DIM;
    localparam logic [SIZE_W-1:0] DIM_LIM = SIZE_W'(DIM_CAP);
    localparam int POS_W = ($clog2(MAX_DIM) < SIZE_W) ? $clog2(MAX_DIM) : SIZE_W;
    localparam int ENT_W = 3 * POS_W + 2;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [PAD_W-1:0]  pad_x_reg, pad_y_reg, pad_z_reg;
    reg_idx_t          reg_idx;
    logic              cfg_wr;
    cfg_t              cfg;

    logic              q_push_valid;
    logic [ENT_W-1:0]  q_push_data;
    logic              q_push_ready;
    logic              q_head_valid;
    logic [ENT_W-1:0]  q_head_data;
    logic              q_pop;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_W'(512);
            size_y_reg <= SIZE_W'(512);
            size_z_reg <= SIZE_W'(512);
            pad_x_reg  <= '0;
            pad_y_reg  <= '0;
            pad_z_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SIZE_X: size_x_reg <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y: size_y_reg <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z: size_z_reg <= pwdata[SIZE_W-1:0];
                REG_PAD_X:  pad_x_reg  <= pwdata[PAD_W-1:0];
                REG_PAD_Y:  pad_y_reg  <= pwdata[PAD_W-1:0];
                REG_PAD_Z:  pad_z_reg  <= pwdata[PAD_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (reg_idx)
            REG_SIZE_X: prdata = DATA_W'(size_x_reg);
            REG_SIZE_Y: prdata = DATA_W'(size_y_reg);
            REG_SIZE_Z: prdata = DATA_W'(size_z_reg);
            REG_PAD_X:  prdata = DATA_W'(pad_x_reg);
            REG_PAD_Y:  prdata = DATA_W'(pad_y_reg);
            REG_PAD_Z:  prdata = DATA_W'(pad_z_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective sizes: zero acts as one, oversize saturates at the limit.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0)
        begin
            return SIZE_W'(1);
        end
        return (s > DIM_LIM) ? DIM_LIM : s;
    endfunction

    assign cfg.size_x = eff_size(size_x_reg);
    assign cfg.size_y = eff_size(size_y_reg);
    assign cfg.size_z = eff_size(size_z_reg);
    assign cfg.pad_x  = pad_x_reg;
    assign cfg.pad_y  = pad_y_reg;
    assign cfg.pad_z  = pad_z_reg;

    // Intake, queue and box update.
    bbf_front #(
        .POS_W      (POS_W),
        .LABEL_BITS (LABEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .push_valid (q_push_valid),
        .push_data  (q_push_data),
        .push_ready (q_push_ready)
    );

    bbf_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop)
    );

    bbf_back #(
        .POS_W (POS_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .cfg        (cfg),
        .out_ch     (out_ch)
    );

`ifndef NO_ASSERTIONS
    // A full queue always has a head entry to offer the back end.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_push_ready |-> q_head_valid)
        else $error("queue full while reporting empty");

    // A new result only comes from a pending end-of-volume snapshot.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(u_back.fin_v_reg))
        else $error("result without a pending snapshot");

    // The back end never drains an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire
